/* design/salc_pkg.sv */
// salc_pkg: shared types and constants for the set-associative cache LRU controller.
// Request and result payloads, configuration register indexes, controller/datapath links.
// No dependencies.
package salc_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WB_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDX_BITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_USED = 2'd3;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [ADDR_BITS-1:0] access_address;
    } t_in_req;

    typedef struct packed {
        logic        was_hit;
        logic [1:0]  way_touched;
        logic        line_filled;
        logic        dirty_evicted;
        logic [1:0]  memory_refs_now;
        logic [31:0] total_hits;
        logic [31:0] total_misses;
        logic [31:0] total_memory_refs;
        logic [31:0] total_accesses;
    } t_out_res;

    // controller -> datapath
    typedef struct packed {
        logic load;    // take the request, start the set read
        logic commit;  // resolve the lookup, write back, load the result
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_blocked;  // result register full and held by the receiver
    } t_dp_status;

endpackage

/* design/salc_ram.sv */
// salc_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module salc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [DATA_W-1:0]                        i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [DATA_W-1:0]                        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/salc_ctrl.sv */
// salc_ctrl: request sequencer for the cache controller.
// Two steps per request: set read, then resolve and write back. Uses salc_pkg.
module salc_ctrl
    import salc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic {S_IDLE, S_LOOK} t_state;

    t_state r_state, n_state;
    logic   r_in_stall, n_in_stall;

    always_comb begin
        n_state    = r_state;
        n_in_stall = r_in_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state    = S_LOOK;
                    n_in_stall = 1'b1;
                end
            end
            S_LOOK: begin
                // hold while the previous result is still unread
                if (!i_status.out_blocked) begin
                    n_state    = S_IDLE;
                    n_in_stall = 1'b0;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_in_stall = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_in_stall   = r_in_stall;
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit = (r_state == S_LOOK) && !i_status.out_blocked;

endmodule

/* design/salc_dpath.sv */
// salc_dpath: tag/stamp store, valid and dirty bits, lookup, LRU victim choice,
// counters, configuration registers and result register. Uses salc_pkg, salc_ram.
module salc_dpath
    import salc_pkg::*;
#(
    parameter int SET_COUNT  = 16,
    parameter int NUM_WAYS   = 4,
    parameter int STAMP_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_req               i_in_req,
    input  t_ctrl_cmd             i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_res              o_out_res
);

    localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int MAX_IB = $clog2(SET_COUNT);
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ENT_W  = ADDR_BITS + STAMP_BITS;
    localparam int ROW_W  = NUM_WAYS * ENT_W;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    // configuration
    logic       r_wb_mode;
    logic [3:0] r_off_bits;
    logic [2:0] r_idx_bits;
    logic [2:0] r_ways_used;

    // request held across the lookup
    logic [SET_W-1:0]     r_set;
    logic [ADDR_BITS-1:0] r_tag;
    logic                 r_is_write;

    logic [NUM_WAYS-1:0]   r_line_valid [SET_COUNT];
    logic [NUM_WAYS-1:0]   r_line_dirty [SET_COUNT];
    logic [STAMP_BITS-1:0] r_seq;
    logic [31:0]           r_hits, r_misses, r_memrefs, r_accesses;
    logic                  r_out_valid;
    t_out_res              r_out_res;

    // address decode
    logic [ADDR_BITS-1:0] shifted;
    logic [3:0]           ib;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     set_raw;
    logic [SET_W-1:0]     set_idx;
    logic [ADDR_BITS-1:0] tag_in;

    // lookup
    logic [ROW_W-1:0]      rd_row, wr_row;
    logic [ADDR_BITS-1:0]  row_tag   [NUM_WAYS];
    logic [STAMP_BITS-1:0] row_stamp [NUM_WAYS];
    logic [4:0]            nw;
    logic [NUM_WAYS-1:0]   way_en;
    logic [NUM_WAYS-1:0]   vrow, drow;
    logic                  hit, found_inv, alloc, evict_dirty;
    logic [WAY_W-1:0]      hit_way, inv_way, lru_way, way;
    logic [STAMP_BITS-1:0] low;
    logic [STAMP_BITS-1:0] new_seq;
    logic [1:0]            refs;
    logic                  row_we;

    always_comb begin
        shifted  = i_in_req.access_address >> r_off_bits;
        ib       = ({1'b0, r_idx_bits} > 4'(MAX_IB)) ? 4'(MAX_IB) : {1'b0, r_idx_bits};
        set_mask = ~({SET_W{1'b1}} << ib);
        set_raw  = shifted[SET_W-1:0] & set_mask;
        // wrap into the set count; raw index stays below twice that
        set_idx  = ({1'b0, set_raw} >= (SET_W+1)'(SET_COUNT)) ?
                   set_raw - SET_W'(SET_COUNT) : set_raw;
        tag_in   = i_in_req.access_address >> (5'(r_off_bits) + 5'(ib));
    end

    salc_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (SET_COUNT)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_set),
        .i_wdata (wr_row),
        .i_re    (i_cmd.load),
        .i_raddr (set_idx),
        .o_rdata (rd_row)
    );

    always_comb begin
        nw = (r_ways_used == 3'd0) ? 5'd1 :
             ((5'(r_ways_used) > 5'(NUM_WAYS)) ? 5'(NUM_WAYS) : 5'(r_ways_used));
        for (int w = 0; w < NUM_WAYS; w++) begin
            {row_tag[w], row_stamp[w]} = rd_row[w*ENT_W +: ENT_W];
            way_en[w] = 5'(w) < nw;
        end
        vrow = r_line_valid[r_set];
        drow = r_line_dirty[r_set];
    end

    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        found_inv = 1'b0;
        inv_way   = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!hit && way_en[w] && vrow[w] && (row_tag[w] == r_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!found_inv && way_en[w] && !vrow[w]) begin
                found_inv = 1'b1;
                inv_way   = WAY_W'(w);
            end
        end
        // lowest stamp, first one wins a tie
        low     = row_stamp[0];
        lru_way = '0;
        for (int w = 1; w < NUM_WAYS; w++) begin
            if (way_en[w] && (row_stamp[w] < low)) begin
                low     = row_stamp[w];
                lru_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        new_seq     = (r_seq == STAMP_MAX) ? r_seq : r_seq + STAMP_BITS'(1);
        alloc       = !hit && ((r_is_write == CMD_READ) || r_wb_mode);
        evict_dirty = alloc && !found_inv && drow[lru_way];
        if (hit) begin
            way = hit_way;
        end else if (alloc) begin
            way = found_inv ? inv_way : lru_way;
        end else begin
            way = '0;
        end
        if (hit) begin
            refs = (r_is_write && !r_wb_mode) ? 2'd1 : 2'd0;
        end else begin
            refs = evict_dirty ? 2'd2 : 2'd1;
        end
        wr_row = rd_row;
        wr_row[way*ENT_W +: ENT_W] = {r_tag, new_seq};
        row_we = i_cmd.commit && (hit || alloc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_mode   <= 1'b0;
            r_off_bits  <= 4'd2;
            r_idx_bits  <= 3'd2;
            r_ways_used <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WB_MODE:   r_wb_mode   <= i_cfg_data[0];
                REG_OFF_BITS:  r_off_bits  <= i_cfg_data[3:0];
                REG_IDX_BITS:  r_idx_bits  <= i_cfg_data[2:0];
                REG_WAYS_USED: r_ways_used <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set      <= set_idx;
            r_tag      <= tag_in;
            r_is_write <= (i_in_req.cmd == CMD_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SET_COUNT; s++) begin
                r_line_valid[s] <= '0;
                r_line_dirty[s] <= '0;
            end
            r_seq      <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_memrefs  <= '0;
            r_accesses <= '0;
        end else if (i_cmd.commit) begin
            if (alloc) begin
                r_line_valid[r_set][way] <= 1'b1;
                r_line_dirty[r_set][way] <= r_is_write;
            end else if (hit && r_is_write && r_wb_mode) begin
                r_line_dirty[r_set][way] <= 1'b1;
            end
            r_seq      <= new_seq;
            r_hits     <= r_hits + 32'(hit);
            r_misses   <= r_misses + 32'(!hit);
            r_memrefs  <= r_memrefs + 32'(refs);
            r_accesses <= r_accesses + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_res.was_hit           <= hit;
            r_out_res.way_touched       <= 2'(way);
            r_out_res.line_filled       <= alloc;
            r_out_res.dirty_evicted     <= evict_dirty;
            r_out_res.memory_refs_now   <= refs;
            r_out_res.total_hits        <= r_hits + 32'(hit);
            r_out_res.total_misses      <= r_misses + 32'(!hit);
            r_out_res.total_memory_refs <= r_memrefs + 32'(refs);
            r_out_res.total_accesses    <= r_accesses + 32'd1;
        end
    end

    assign o_status.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid          = r_out_valid;
    assign o_out_res            = r_out_res;

`ifndef NO_ASSERTIONS
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(hit && (alloc || evict_dirty)))
        else $error("hit resolved together with a fill or eviction");

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_res.total_hits + o_out_res.total_misses)
                         == o_out_res.total_accesses))
        else $error("hit and miss counts disagree with access count");

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_seq != $past(r_seq)) || (r_seq == STAMP_MAX))
        else $error("access stamp did not advance");

    a_refs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_res.memory_refs_now != 2'd3))
        else $error("memory reference count out of range");

    a_load_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> !o_out_valid || i_cmd.commit || $past(o_out_valid))
        else $error("result appeared without a commit");
`endif

endmodule

/* design/set_assoc_cache_lru_controller_top.sv */
// Set-associative cache tag store with LRU replacement, write-through or write-back.
// For each request the set's tag/stamp row is first read from the RAM; then the ways are
// compared, the victim picked and the row written back. A new request is taken in the
// cycle after the result is loaded; while a result waits unread, the second step holds
// until the output register frees. Valid and dirty bits live in flip-flops cleared by
// reset, so no clearing pass is needed. Uses salc_pkg, salc_ctrl, salc_dpath.
module set_assoc_cache_lru_controller_top
    import salc_pkg::*;
#(
    parameter int SET_COUNT  = 16,
    parameter int NUM_WAYS   = 4,
    parameter int STAMP_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_res              o_out_res
);

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    salc_dpath #(
        .SET_COUNT  (SET_COUNT),
        .NUM_WAYS   (NUM_WAYS),
        .STAMP_BITS (STAMP_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

endmodule
